[hdl/atclp_pkg.sv]
// ----------------------------------------------------------------------------
// atclp_pkg
// Shared types, codes and character constants of the AT command line parser.
// ----------------------------------------------------------------------------
package atclp_pkg;

    localparam logic [2:0] PH_A    = 3'd0;
    localparam logic [2:0] PH_T    = 3'd1;
    localparam logic [2:0] PH_NAME = 3'd2;
    localparam logic [2:0] PH_EQ   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic [2:0] ST_MATCHED  = 3'd0;
    localparam logic [2:0] ST_NO_AT    = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_AT   = 2'd1;
    localparam logic [1:0] ERR_BAD_CHR = 2'd2;

    localparam logic [1:0] TYPE_RUN   = 2'd0;
    localparam logic [1:0] TYPE_READ  = 2'd1;
    localparam logic [1:0] TYPE_TEST  = 2'd2;
    localparam logic [1:0] TYPE_WRITE = 2'd3;

    localparam logic [7:0] CFG_COMMANDS   = 8'd0;
    localparam logic [7:0] CFG_LINE_LIMIT = 8'd1;
    localparam logic [7:0] CFG_TERM_FIRST = 8'd2;
    localparam logic [7:0] CFG_TERM_SECND = 8'd3;
    localparam logic [7:0] CFG_TERM_LEN   = 8'd4;
    localparam logic [7:0] CFG_TBL_ENTRY  = 8'd5;
    localparam logic [7:0] CFG_TBL_POS    = 8'd6;
    localparam logic [7:0] CFG_TBL_CHAR   = 8'd7;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_QUERY = 8'h3F;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_DOLR  = 8'h24;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    localparam logic [6:0] PREFIX_AND_EQ = 7'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] command_type;
        logic [2:0] command_index;
        logic [6:0] param_offset;
        logic [6:0] param_length;
    } t_result;

    typedef struct packed {
        logic step;
        logic clear;
        logic feed;
        logic kill;
        logic long_name;
    } t_cell_ctl;

    function automatic logic valid_name_char(input logic [7:0] c);
        return (c >= CHAR_A && c <= CHAR_Z) || (c >= CHAR_0 && c <= CHAR_9) ||
               c == CHAR_PLUS || c == CHAR_HASH || c == CHAR_DOLR || c == CHAR_AT ||
               c == CHAR_UNDER || c == CHAR_EQ || c == CHAR_QUERY;
    endfunction

endpackage

[hdl/atclp_if.sv]
// ----------------------------------------------------------------------------
// atclp_if
// Handshake channels of the parser: received bytes, results and configuration.
// ----------------------------------------------------------------------------
interface atclp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface atclp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] command_type;
    logic [2:0] command_index;
    logic [6:0] param_offset;
    logic [6:0] param_length;

    modport source (output valid, output status, output command_type,
                    output command_index, output param_offset, output param_length,
                    input ready);
    modport sink (input valid, input status, input command_type,
                  input command_index, input param_offset, input param_length,
                  output ready);
endinterface

interface atclp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/at_command_line_parser.sv]
// ----------------------------------------------------------------------------
// at_command_line_parser
// Parses received bytes into AT command lines and matches each command name
// against a loaded table, one result per non-empty terminated line or overflow.
//
//   Channel   Direction  Payload                                   Handshake
//   i_cfg     in         index, data                               valid/ready
//   i_byte    in         rx_byte                                   valid/ready
//   o_result  out        status, command_type, command_index,      valid/ready
//                        param_offset, param_length
//
// One byte is taken in every cycle; a row of table cells compares it against
// all entries at once, and the result of a line is registered in a result
// buffer. This two-entry buffer lets bytes flow while a result waits; input
// stalls only when both entries are full. Reset clears the line state at once;
// the name table holds no reset value and must be loaded.
// ----------------------------------------------------------------------------
module at_command_line_parser #(
    parameter int NUM_COMMANDS = 8,
    parameter int NAME_CHARS   = 16,
    parameter int BUFFER_SIZE  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    atclp_cfg_if.sink       i_cfg,
    atclp_byte_if.sink      i_byte,
    atclp_result_if.source  o_result
);

    localparam int PW    = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int NL_W  = $clog2(NAME_CHARS + 1);
    localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
    localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;

    logic [3:0]       r_commands;
    logic [6:0]       r_limit;
    logic [7:0]       r_term1;
    logic [7:0]       r_term2;
    logic [1:0]       r_tlen;
    logic [2:0]       r_tbl_entry;
    logic [3:0]       r_tbl_pos;

    logic [CNT_W-1:0] r_count;
    logic             r_tpos;
    logic [2:0]       r_phase;
    logic [NL_W-1:0]  r_len;
    logic [1:0]       r_err;
    logic [1:0]       r_type;

    logic [CNT_W-1:0] n_count;
    logic [2:0]       n_phase;
    logic [NL_W-1:0]  n_len;
    logic [1:0]       n_err;
    logic [1:0]       n_type;

    logic             w_in_ready;
    logic             w_acc;
    logic [7:0]       w_b;
    logic             w_nz;
    logic [LIM_W-1:0] w_limit;
    logic             w_over;
    logic             w_feed;
    logic             w_name_feed;
    logic             w_name_kill;
    logic [7:0]       w_expect;
    logic             w_tmatch;
    logic             w_fin;
    logic             w_emit;
    logic             w_hit;
    logic [2:0]       w_idx;
    logic [1:0]       w_ftype;
    logic [6:0]       w_off;
    logic             w_tbl_wr;
    logic             w_pos_ok;
    atclp_pkg::t_cell_ctl w_ctl;
    atclp_pkg::t_result   w_res;

    logic [NUM_COMMANDS-1:0] w_first;
    logic [NUM_COMMANDS:0]   w_taken;

    assign i_cfg.ready = 1'b1;
    assign w_b   = i_byte.rx_byte;
    assign w_acc = i_byte.valid && w_in_ready;
    assign i_byte.ready = w_in_ready;

    assign w_tbl_wr = i_cfg.valid && (i_cfg.index == atclp_pkg::CFG_TBL_CHAR);
    assign w_pos_ok = ({28'd0, r_tbl_pos} < NAME_CHARS);

    always_comb begin
        w_limit = (LIM_W'(r_limit) > LIM_W'(BUFFER_SIZE)) ? LIM_W'(BUFFER_SIZE)
                                                           : LIM_W'(r_limit);
        w_nz    = (w_b != 8'd0);
        w_over  = w_nz && (LIM_W'(r_count) >= w_limit);
        w_feed  = w_nz && !w_over && (w_b != atclp_pkg::CHAR_CR) &&
                  (w_b != atclp_pkg::CHAR_LF);

        n_count     = w_feed ? (r_count + CNT_W'(1)) : r_count;
        n_phase     = r_phase;
        n_len       = r_len;
        n_err       = r_err;
        n_type      = r_type;
        w_name_feed = 1'b0;
        w_name_kill = 1'b0;
        if (w_feed) begin
            unique case (r_phase)
                atclp_pkg::PH_A: begin
                    if (w_b == atclp_pkg::CHAR_A) begin
                        n_phase = atclp_pkg::PH_T;
                    end else begin
                        n_err   = atclp_pkg::ERR_NO_AT;
                        n_phase = atclp_pkg::PH_DONE;
                    end
                end
                atclp_pkg::PH_T: begin
                    if (w_b == atclp_pkg::CHAR_T) begin
                        n_phase = atclp_pkg::PH_NAME;
                    end else begin
                        n_err   = atclp_pkg::ERR_NO_AT;
                        n_phase = atclp_pkg::PH_DONE;
                    end
                end
                atclp_pkg::PH_NAME: begin
                    if (!atclp_pkg::valid_name_char(w_b)) begin
                        n_err   = atclp_pkg::ERR_BAD_CHR;
                        n_phase = atclp_pkg::PH_DONE;
                    end else if (w_b == atclp_pkg::CHAR_EQ) begin
                        n_phase = atclp_pkg::PH_EQ;
                    end else if (w_b == atclp_pkg::CHAR_QUERY) begin
                        n_type  = atclp_pkg::TYPE_READ;
                        n_phase = atclp_pkg::PH_DONE;
                    end else if (r_len >= NL_W'(NAME_CHARS)) begin
                        w_name_kill = 1'b1;
                    end else begin
                        w_name_feed = 1'b1;
                        n_len       = r_len + NL_W'(1);
                    end
                end
                atclp_pkg::PH_EQ: begin
                    n_type  = (w_b == atclp_pkg::CHAR_QUERY) ? atclp_pkg::TYPE_TEST
                                                             : atclp_pkg::TYPE_WRITE;
                    n_phase = atclp_pkg::PH_DONE;
                end
                default: begin
                end
            endcase
        end

        w_expect = r_tpos ? r_term2 : r_term1;
        w_tmatch = (w_b == w_expect);
        w_fin    = w_nz && !w_over && w_tmatch && (r_tpos || (r_tlen < 2'd2));
        w_emit   = w_acc && (w_over || (w_fin && (n_count != CNT_W'(0))));
    end

    assign w_ctl.step      = w_acc && w_nz;
    assign w_ctl.clear     = w_over || w_fin;
    assign w_ctl.feed      = w_name_feed;
    assign w_ctl.kill      = w_name_kill;
    assign w_ctl.long_name = (n_len >= NL_W'(NAME_CHARS));

    assign w_taken[0] = 1'b0;

    for (genvar e = 0; e < NUM_COMMANDS; e++) begin : g_cells
        atclp_cell #(
            .NAME_CHARS (NAME_CHARS),
            .PW         (PW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_en   (w_tbl_wr && w_pos_ok && ({29'd0, r_tbl_entry} == e)),
            .i_wr_pos  (PW'(r_tbl_pos)),
            .i_wr_char (i_cfg.data),
            .i_char    (w_b),
            .i_rd_pos  (r_len[PW-1:0]),
            .i_end_pos (n_len[PW-1:0]),
            .i_enable  (e < {28'd0, r_commands}),
            .i_taken   (w_taken[e]),
            .o_taken   (w_taken[e+1]),
            .o_first   (w_first[e])
        );
    end

    always_comb begin
        w_hit = w_taken[NUM_COMMANDS];
        w_idx = 3'd0;
        for (int e = 0; e < NUM_COMMANDS; e++) begin
            if (w_first[e]) begin
                w_idx = w_idx | 3'(e);
            end
        end
        w_ftype = (n_phase == atclp_pkg::PH_EQ) ? atclp_pkg::TYPE_WRITE : n_type;
        w_off   = 7'(n_len) + atclp_pkg::PREFIX_AND_EQ;

        w_res = '0;
        priority if (w_over) begin
            w_res.status = atclp_pkg::ST_OVERFLOW;
        end else if (n_err != atclp_pkg::ERR_NONE) begin
            w_res.status = {1'b0, n_err};
        end else if (n_phase == atclp_pkg::PH_A || n_phase == atclp_pkg::PH_T) begin
            w_res.status = atclp_pkg::ST_NO_AT;
        end else if (!w_hit) begin
            w_res.status = atclp_pkg::ST_UNKNOWN;
        end else begin
            w_res.status        = atclp_pkg::ST_MATCHED;
            w_res.command_type  = w_ftype;
            w_res.command_index = w_idx;
            if (w_ftype == atclp_pkg::TYPE_WRITE) begin
                w_res.param_offset = w_off;
                w_res.param_length = 7'(n_count) - w_off;
            end
        end
    end

    atclp_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_emit),
        .i_data   (w_res),
        .o_ready  (w_in_ready),
        .o_result (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commands  <= 4'd0;
            r_limit     <= 7'd64;
            r_term1     <= atclp_pkg::CHAR_CR;
            r_term2     <= atclp_pkg::CHAR_LF;
            r_tlen      <= 2'd2;
            r_tbl_entry <= 3'd0;
            r_tbl_pos   <= 4'd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                atclp_pkg::CFG_COMMANDS:   r_commands  <= i_cfg.data[3:0];
                atclp_pkg::CFG_LINE_LIMIT: r_limit     <= i_cfg.data[6:0];
                atclp_pkg::CFG_TERM_FIRST: r_term1     <= i_cfg.data;
                atclp_pkg::CFG_TERM_SECND: r_term2     <= i_cfg.data;
                atclp_pkg::CFG_TERM_LEN:   r_tlen      <= i_cfg.data[1:0];
                atclp_pkg::CFG_TBL_ENTRY:  r_tbl_entry <= i_cfg.data[2:0];
                atclp_pkg::CFG_TBL_POS:    r_tbl_pos   <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tpos  <= 1'b0;
            r_phase <= atclp_pkg::PH_A;
            r_len   <= '0;
            r_err   <= atclp_pkg::ERR_NONE;
            r_type  <= atclp_pkg::TYPE_RUN;
        end else if (w_acc && w_nz) begin
            if (w_over || w_fin) begin
                r_count <= '0;
                r_tpos  <= 1'b0;
                r_phase <= atclp_pkg::PH_A;
                r_len   <= '0;
                r_err   <= atclp_pkg::ERR_NONE;
                r_type  <= atclp_pkg::TYPE_RUN;
            end else begin
                r_count <= n_count;
                r_tpos  <= w_tmatch;
                r_phase <= n_phase;
                r_len   <= n_len;
                r_err   <= n_err;
                r_type  <= n_type;
            end
        end
    end

endmodule

[hdl/atclp_cell.sv]
// ----------------------------------------------------------------------------
// atclp_cell
// One name table entry with its alive flag; the first hit travels down the row.
// ----------------------------------------------------------------------------
module atclp_cell #(
    parameter int NAME_CHARS = 16,
    parameter int PW         = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atclp_pkg::t_cell_ctl i_ctl,
    input  logic                 i_wr_en,
    input  logic [PW-1:0]        i_wr_pos,
    input  logic [7:0]           i_wr_char,
    input  logic [7:0]           i_char,
    input  logic [PW-1:0]        i_rd_pos,
    input  logic [PW-1:0]        i_end_pos,
    input  logic                 i_enable,
    input  logic                 i_taken,
    output logic                 o_taken,
    output logic                 o_first
);

    logic [7:0] r_row [NAME_CHARS];
    logic       r_zero [NAME_CHARS];
    logic       r_alive;
    logic       n_alive;
    logic       w_cand;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row[i_wr_pos]  <= i_wr_char;
            r_zero[i_wr_pos] <= (i_wr_char == 8'd0);
        end
    end

    always_comb begin
        n_alive = r_alive;
        if (i_ctl.kill) begin
            n_alive = 1'b0;
        end else if (i_ctl.feed) begin
            n_alive = r_alive && (r_row[i_rd_pos] == i_char);
        end
        w_cand  = n_alive && i_enable && (i_ctl.long_name || r_zero[i_end_pos]);
        o_first = w_cand && !i_taken;
        o_taken = w_cand || i_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b1;
        end else if (i_ctl.step) begin
            r_alive <= i_ctl.clear ? 1'b1 : n_alive;
        end
    end

endmodule

[hdl/atclp_out_queue.sv]
// ----------------------------------------------------------------------------
// atclp_out_queue
// Two-entry result buffer that decouples the parser from the result sink.
// ----------------------------------------------------------------------------
module atclp_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  atclp_pkg::t_result    i_data,
    output logic                  o_ready,
    atclp_result_if.source        o_result
);

    atclp_pkg::t_result r_head;
    atclp_pkg::t_result r_tail;
    logic [1:0]         r_cnt;
    logic               w_pop;
    logic               w_to_head;

    assign w_pop     = (r_cnt != 2'd0) && o_result.ready;
    assign o_ready   = (r_cnt != 2'd2);
    assign w_to_head = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push && w_to_head) begin
            r_head <= i_data;
        end else if (w_pop) begin
            r_head <= r_tail;
        end
        if (i_push && !w_to_head) begin
            r_tail <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    assign o_result.valid         = (r_cnt != 2'd0);
    assign o_result.status        = r_head.status;
    assign o_result.command_type  = r_head.command_type;
    assign o_result.command_index = r_head.command_index;
    assign o_result.param_offset  = r_head.param_offset;
    assign o_result.param_length  = r_head.param_length;

endmodule
